// ===== hw/rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W          = 8;
    localparam int TIME_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int QCOUNT_W      = 4;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 8'd3;

    typedef enum logic
    {
        OP_ADMIT = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_ADMITTED = 3'd0,
        ST_REQUEUED = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed
    {
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] remaining;
    } q_entry_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } q_stat_t;

endpackage

// ===== hw/rtl/round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps

// Round-robin scheduler with a time quantum over an 8-entry process queue.
// Input stream (s_*): tuser is the opcode (0 admit, 1 step), tdata carries
// proc_id and burst_time. Output stream (m_*): one result per input transfer,
// tuser is the status code, tdata carries out_proc_id, out_remaining and
// queue_count. cfg_we/cfg_wdata write the quantum (reset value 3); write only
// while the block is idle.
// An admit, a rejected admit or a step on an empty queue presents its result
// in the cycle after the input transfer. A step on a non-empty queue reads the
// head entry from the queue memory into the queue read register, and in state
// S_RUN writes a requeued entry back at the tail while the result is loaded
// into the output register.
// Throughput: one admit per cycle while the receiver takes each result; a step
// takes no new transfer until its write-back in S_RUN, where s_tready is low.
// The result sits in an output register; s_tready is high in the idle state
// while that register is empty or being drained, so a stalled receiver stops
// further transfers until it takes the result. Reset empties the queue and
// restores the quantum; memory contents are not cleared.
module round_robin_time_slice_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] proc_id, [15:8] burst_time
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_proc_id, [15:8] out_remaining,
                                   // [19:16] queue_count, [23:20] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [rrts_pkg::TIME_W-1:0]  quantum_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    rrts_pkg::status_t            status_reg;
    rrts_pkg::status_t            status_next;
    logic [rrts_pkg::ID_W-1:0]    pid_reg;
    logic [rrts_pkg::ID_W-1:0]    pid_next;
    logic [rrts_pkg::TIME_W-1:0]  rem_reg;
    logic [rrts_pkg::TIME_W-1:0]  rem_next;
    logic [rrts_pkg::QCOUNT_W-1:0] qcount_reg;
    logic [rrts_pkg::QCOUNT_W-1:0] qcount_next;

    logic                         accept;
    logic                         load;
    rrts_pkg::opcode_t            opcode;
    logic [rrts_pkg::ID_W-1:0]    in_pid;
    logic [rrts_pkg::TIME_W-1:0]  in_burst;

    rrts_pkg::q_ctrl_t            q_ctrl;
    rrts_pkg::q_entry_t           q_push_data;
    rrts_pkg::q_entry_t           q_rd_data;
    rrts_pkg::q_stat_t            q_stat;

    assign opcode   = rrts_pkg::opcode_t'(s_tuser);
    assign in_pid   = s_tdata[7:0];
    assign in_burst = s_tdata[15:8];
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    rrts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (q_push_data),
        .rd_data   (q_rd_data),
        .stat      (q_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        q_ctrl      = '0;
        q_push_data = '0;
        load        = 1'b0;
        status_next = status_reg;
        pid_next    = pid_reg;
        rem_next    = rem_reg;
        qcount_next = qcount_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == rrts_pkg::OP_ADMIT)
                    begin
                        load = 1'b1;
                        if (q_stat.full)
                        begin
                            status_next = rrts_pkg::ST_FULL;
                            pid_next    = '0;
                            rem_next    = '0;
                            qcount_next = rrts_pkg::QCOUNT_W'(q_stat.count);
                        end
                        else
                        begin
                            q_ctrl.push           = 1'b1;
                            q_push_data.pid       = in_pid;
                            q_push_data.remaining = in_burst;
                            status_next = rrts_pkg::ST_ADMITTED;
                            pid_next    = in_pid;
                            rem_next    = in_burst;
                            qcount_next = rrts_pkg::QCOUNT_W'(q_stat.count
                                          + rrts_pkg::CNT_W'(1));
                        end
                    end
                    else if (q_stat.empty)
                    begin
                        load        = 1'b1;
                        status_next = rrts_pkg::ST_EMPTY;
                        pid_next    = '0;
                        rem_next    = '0;
                        qcount_next = '0;
                    end
                    else
                    begin
                        q_ctrl.pop = 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                load       = 1'b1;
                state_next = S_IDLE;
                pid_next   = q_rd_data.pid;
                if (q_rd_data.remaining > quantum_reg)
                begin
                    q_ctrl.push           = 1'b1;
                    q_push_data.pid       = q_rd_data.pid;
                    q_push_data.remaining = q_rd_data.remaining - quantum_reg;
                    status_next = rrts_pkg::ST_REQUEUED;
                    rem_next    = q_rd_data.remaining - quantum_reg;
                    qcount_next = rrts_pkg::QCOUNT_W'(q_stat.count
                                  + rrts_pkg::CNT_W'(1));
                end
                else
                begin
                    status_next = rrts_pkg::ST_COMPLETE;
                    rem_next    = '0;
                    qcount_next = rrts_pkg::QCOUNT_W'(q_stat.count);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            quantum_reg   <= rrts_pkg::QUANTUM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pid_reg    <= pid_next;
        rem_reg    <= rem_next;
        qcount_reg <= qcount_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, qcount_reg, rem_reg, pid_reg};

`ifndef SYNTHESIS
    a_run_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !out_valid_reg)
        else $error("output register busy during step");

    a_run_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("step did not finish in one cycle");

    a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctrl.pop |=> (state_reg == S_RUN))
        else $error("head read without step");
`endif

endmodule

// ===== hw/rtl/rrts_queue.sv =====
`timescale 1ns / 1ps

module rrts_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  rrts_pkg::q_ctrl_t ctrl,
    input  rrts_pkg::q_entry_t push_data,
    output rrts_pkg::q_entry_t rd_data,
    output rrts_pkg::q_stat_t  stat
);

    rrts_pkg::q_entry_t mem [rrts_pkg::QUEUE_DEPTH];
    rrts_pkg::q_entry_t rd_data_reg;

    logic [rrts_pkg::PTR_W-1:0] head_reg;
    logic [rrts_pkg::PTR_W-1:0] head_next;
    logic [rrts_pkg::PTR_W-1:0] tail_reg;
    logic [rrts_pkg::PTR_W-1:0] tail_next;
    logic [rrts_pkg::CNT_W-1:0] count_reg;
    logic [rrts_pkg::CNT_W-1:0] count_next;

    localparam logic [rrts_pkg::PTR_W-1:0] PTR_LAST =
        rrts_pkg::PTR_W'(rrts_pkg::QUEUE_DEPTH - 1);
    localparam logic [rrts_pkg::CNT_W-1:0] CNT_FULL =
        rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + rrts_pkg::PTR_W'(1);
        end
        if (ctrl.push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + rrts_pkg::PTR_W'(1);
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + rrts_pkg::CNT_W'(1);
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - rrts_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg >= CNT_FULL);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> !stat.full)
        else $error("push into full queue");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.empty || stat.full) |-> (head_reg == tail_reg))
        else $error("pointers disagree with count");
`endif

endmodule

// ===== bench/round_robin_time_slice_scheduler_tb.sv =====
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed
    {
        rrts_pkg::status_t           status;
        logic [rrts_pkg::ID_W-1:0]   pid;
        logic [rrts_pkg::TIME_W-1:0] remaining;
        logic [3:0]                  count;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    rrts_pkg::q_entry_t run_queue[$];
    sched_result_t      expected_results[$];
    logic [7:0]         quantum_now;
    int unsigned        mismatch_count;
    int unsigned        cycle_count;
    bit                 tx_gaps;
    bit                 rx_stalls;

    round_robin_time_slice_scheduler i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // expected result of one accepted transfer, advancing the scheduler state
    task automatic schedule_item(rrts_pkg::opcode_t op, logic [7:0] pid,
                                 logic [7:0] burst);
        sched_result_t      res;
        rrts_pkg::q_entry_t head;
        res = '{status: rrts_pkg::ST_EMPTY, pid: '0, remaining: '0, count: '0};
        if (op == rrts_pkg::OP_ADMIT)
        begin
            if (run_queue.size() >= rrts_pkg::QUEUE_DEPTH)
                res.status = rrts_pkg::ST_FULL;
            else
            begin
                run_queue.push_back('{pid: pid, remaining: burst});
                res.status = rrts_pkg::ST_ADMITTED;
                res.pid = pid;
                res.remaining = burst;
            end
        end
        else if (run_queue.size() != 0)
        begin
            head = run_queue.pop_front();
            res.pid = head.pid;
            if (head.remaining > quantum_now)
            begin
                head.remaining = head.remaining - quantum_now;
                run_queue.push_back(head);
                res.status = rrts_pkg::ST_REQUEUED;
                res.remaining = head.remaining;
            end
            else
                res.status = rrts_pkg::ST_COMPLETE;
        end
        res.count = 4'(run_queue.size());
        expected_results.push_back(res);
    endtask

    task automatic check_result();
        sched_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: status %0d data %h", m_tuser, m_tdata);
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser !== want.status || m_tdata[7:0] !== want.pid
            || m_tdata[15:8] !== want.remaining || m_tdata[19:16] !== want.count
            || m_tdata[23:20] !== 4'd0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display({"mismatch: expected status %0d id %0d rem %0d count %0d, ",
                          "got status %0d id %0d rem %0d count %0d pad %h"},
                         want.status, want.pid, want.remaining, want.count, m_tuser,
                         m_tdata[7:0], m_tdata[15:8], m_tdata[19:16], m_tdata[23:20]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rx_stalls && $urandom_range(0, 99) < 30)
            begin
                m_tready <= 1'b0;
                repeat (gap_len() - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(rrts_pkg::opcode_t op, logic [7:0] pid, logic [7:0] burst);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {burst, pid};
        do
            @(posedge clk);
        while (!s_tready);
        schedule_item(op, pid, burst);
        if (tx_gaps && $urandom_range(0, 99) < 35)
        begin
            repeat (gap_len())
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata <= 16'($urandom);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_quantum(logic [7:0] q);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= q;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 8'($urandom);
        quantum_now = q;
    endtask

    task automatic test_step_on_empty();
        send_item(rrts_pkg::OP_STEP, 8'hff, 8'hff);
    endtask

    task automatic test_fill_and_reject();
        send_item(rrts_pkg::OP_ADMIT, 8'h00, 8'h00);
        send_item(rrts_pkg::OP_ADMIT, 8'hff, 8'hff);
        send_item(rrts_pkg::OP_ADMIT, 8'haa, 8'h03);
        send_item(rrts_pkg::OP_ADMIT, 8'h55, 8'h04);
        send_item(rrts_pkg::OP_ADMIT, 8'h01, 8'h01);
        send_item(rrts_pkg::OP_ADMIT, 8'h02, 8'h02);
        send_item(rrts_pkg::OP_ADMIT, 8'h80, 8'h80);
        send_item(rrts_pkg::OP_ADMIT, 8'h7f, 8'h7f);
        send_item(rrts_pkg::OP_ADMIT, 8'h33, 8'h33);
    endtask

    // zero burst completes, burst equal to quantum completes, larger ones requeue
    task automatic test_default_quantum_steps();
        repeat (4) send_item(rrts_pkg::OP_STEP, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_wide_quantum_drain();
        set_quantum(8'd255);
        repeat (7) send_item(rrts_pkg::OP_STEP, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_zero_quantum();
        set_quantum(8'd0);
        send_item(rrts_pkg::OP_ADMIT, 8'h09, 8'h05);
        send_item(rrts_pkg::OP_ADMIT, 8'h0a, 8'h00);
        repeat (3) send_item(rrts_pkg::OP_STEP, 8'($urandom), 8'($urandom));
        set_quantum(8'd255);
        send_item(rrts_pkg::OP_STEP, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_random_phase(logic [7:0] q, int unsigned admit_pct,
                                     int unsigned n_items, bit gaps_on, bit stalls_on);
        int unsigned span;
        logic [7:0]  burst;
        set_quantum(q);
        tx_gaps = gaps_on;
        rx_stalls = stalls_on;
        span = (q * 3 > 255) ? 255 : q * 3 + 1;
        repeat (n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: burst = 8'($urandom_range(0, 255));
                4, 5, 6, 7: burst = 8'($urandom_range(0, span));
                8:          burst = 8'h00;
                default:    burst = 8'hff;
            endcase
            if ($urandom_range(0, 99) < admit_pct)
                send_item(rrts_pkg::OP_ADMIT, 8'($urandom), burst);
            else
                send_item(rrts_pkg::OP_STEP, 8'($urandom), burst);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quantum_now = rrts_pkg::QUANTUM_RESET;
        mismatch_count = 0;
        cycle_count = 0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_step_on_empty();
        test_fill_and_reject();
        test_default_quantum_steps();
        test_wide_quantum_drain();
        test_zero_quantum();

        test_random_phase(8'd1,   50, 150, 1'b0, 1'b0);
        test_random_phase(8'd255, 55, 150, 1'b1, 1'b1);
        test_random_phase(8'd3,   65, 150, 1'b1, 1'b0);
        test_random_phase(8'($urandom_range(2, 20)), 40, 150, 1'b0, 1'b1);
        test_random_phase(8'd0,   45, 100, 1'b1, 1'b1);
        test_random_phase(8'($urandom_range(1, 255)), 55, 150, 1'b1, 1'b1);
        test_random_phase(8'($urandom_range(4, 12)), 50, 200, 1'b1, 1'b1);

        drain_results();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_queue.sv
hw/rtl/round_robin_time_slice_scheduler.sv
bench/round_robin_time_slice_scheduler_tb.sv
